[rtl/bellman_ford_shortest_paths_core_assert.svh]
`ifndef BELLMAN_FORD_SHORTEST_PATHS_CORE_ASSERT_SVH
`define BELLMAN_FORD_SHORTEST_PATHS_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define BFSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define BFSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bfsp_pkg.sv]
package bfsp_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int DIST_W           = 22;
  localparam int VERT_W           = 6;
  localparam int CFG_W            = 7;
  localparam logic [CFG_W-1:0] NUM_VERTICES_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_COMPUTE = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_TAIL,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // What the execute stage does with the distance word read in the previous cycle.
  typedef enum logic [2:0] {
    K_NONE,
    K_INIT,
    K_TAIL,
    K_EDGE,
    K_OUT,
    K_NEG
  } kind_e;

  typedef struct packed {
    kind_e kind;
    logic  detect;
    logic  self_loop;
    logic  seed;
    logic  last;
  } issue_t;

endpackage

[rtl/bfsp_ram.sv]
module bfsp_ram #(
  parameter int WIDTH = bfsp_pkg::DIST_W + 1,
  parameter int DEPTH = bfsp_pkg::MAX_VERTICES_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bfsp_seq.sv]
module bfsp_seq #(
  parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS_DEF,
  localparam int VW   = $clog2(MAX_VERTICES),
  localparam int EA_W = $clog2(MAX_VERTICES * MAX_VERTICES)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [1:0]                     operation_i,
  input  logic [bfsp_pkg::VERT_W-1:0]    from_vertex_i,
  input  logic [bfsp_pkg::VERT_W-1:0]    to_vertex_i,
  input  logic signed [WEIGHT_BITS-1:0]  weight_i,
  input  logic [bfsp_pkg::VERT_W-1:0]    source_vertex_i,
  input  logic                           cfg_we_i,
  input  logic [bfsp_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           cycle_i,
  output logic                           edge_we_o,
  output logic [EA_W-1:0]                edge_waddr_o,
  output logic [WEIGHT_BITS:0]           edge_wdata_o,
  output logic [EA_W-1:0]                edge_raddr_o,
  output bfsp_pkg::issue_t               iss_o,
  output logic [VW-1:0]                  iss_addr_o
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int NV_W  = (CNT_W > bfsp_pkg::CFG_W) ? CNT_W : bfsp_pkg::CFG_W;

  bfsp_pkg::state_e state_q, state_d;

  logic [bfsp_pkg::CFG_W-1:0] num_vertices_q;
  logic [EA_W-1:0]            clr_q;
  logic [EA_W-1:0]            row_q;
  logic [VW-1:0]              j_q, k_q, pass_q, n_m1_q, src_q;
  logic                       src_ok_q, detect_q;

  logic [NV_W-1:0] n_eff;
  logic            accept, src_ok, edge_ok, clr_last, k_end, j_end, neg;

  // Out-of-range register values fold to the nearest usable vertex count.
  always_comb begin
    if (num_vertices_q == '0) begin
      n_eff = NV_W'(1);
    end else if (NV_W'(num_vertices_q) > NV_W'(MAX_VERTICES)) begin
      n_eff = NV_W'(MAX_VERTICES);
    end else begin
      n_eff = NV_W'(num_vertices_q);
    end
  end

  assign accept   = start_i && (state_q == bfsp_pkg::ST_IDLE);
  assign src_ok   = NV_W'(source_vertex_i) < n_eff;
  assign edge_ok  = (int'(from_vertex_i) < MAX_VERTICES) && (int'(to_vertex_i) < MAX_VERTICES);
  assign clr_last = clr_q == EA_W'(MAX_VERTICES * MAX_VERTICES - 1);
  assign k_end    = k_q == n_m1_q;
  assign j_end    = j_q == n_m1_q;
  assign neg      = detect_q && cycle_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bfsp_pkg::ST_CLEAR: begin
        if (clr_last) state_d = bfsp_pkg::ST_IDLE;
      end
      bfsp_pkg::ST_IDLE: begin
        if (accept && operation_i == bfsp_pkg::OP_CLEAR) begin
          state_d = bfsp_pkg::ST_CLEAR;
        end else if (accept && operation_i == bfsp_pkg::OP_COMPUTE) begin
          state_d = bfsp_pkg::ST_INIT;
        end
      end
      bfsp_pkg::ST_INIT: begin
        if (k_end) state_d = src_ok_q ? bfsp_pkg::ST_TAIL : bfsp_pkg::ST_EMIT;
      end
      bfsp_pkg::ST_TAIL: state_d = bfsp_pkg::ST_SCAN;
      bfsp_pkg::ST_SCAN: begin
        if (k_end) begin
          state_d = (j_end && detect_q) ? bfsp_pkg::ST_DRAIN : bfsp_pkg::ST_TAIL;
        end
      end
      bfsp_pkg::ST_DRAIN: state_d = bfsp_pkg::ST_EMIT;
      bfsp_pkg::ST_EMIT: begin
        if (neg || k_end) state_d = bfsp_pkg::ST_IDLE;
      end
      default: state_d = bfsp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o       = state_q != bfsp_pkg::ST_IDLE;
    edge_we_o    = 1'b0;
    edge_waddr_o = clr_q;
    edge_wdata_o = '0;
    edge_raddr_o = EA_W'(row_q + EA_W'(k_q));
    iss_o        = '{kind: bfsp_pkg::K_NONE, detect: 1'b0, self_loop: 1'b0,
                     seed: 1'b0, last: 1'b0};
    iss_addr_o   = k_q;
    case (state_q)
      bfsp_pkg::ST_CLEAR: begin
        edge_we_o = 1'b1;
      end
      bfsp_pkg::ST_IDLE: begin
        if (accept && operation_i == bfsp_pkg::OP_WRITE && edge_ok) begin
          edge_we_o    = 1'b1;
          edge_waddr_o = EA_W'(int'(from_vertex_i) * MAX_VERTICES + int'(to_vertex_i));
          edge_wdata_o = {1'b1, weight_i};
        end
      end
      bfsp_pkg::ST_INIT: begin
        iss_o.kind = bfsp_pkg::K_INIT;
        iss_o.seed = src_ok_q && (k_q == src_q);
      end
      bfsp_pkg::ST_TAIL: begin
        iss_o.kind = bfsp_pkg::K_TAIL;
        iss_addr_o = j_q;
      end
      bfsp_pkg::ST_SCAN: begin
        iss_o.kind      = bfsp_pkg::K_EDGE;
        iss_o.detect    = detect_q;
        iss_o.self_loop = k_q == j_q;
      end
      bfsp_pkg::ST_EMIT: begin
        iss_o.kind = neg ? bfsp_pkg::K_NEG : bfsp_pkg::K_OUT;
        iss_o.last = k_end;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= bfsp_pkg::ST_CLEAR;
      num_vertices_q <= bfsp_pkg::NUM_VERTICES_RESET;
      clr_q          <= '0;
      row_q          <= '0;
      j_q            <= '0;
      k_q            <= '0;
      pass_q         <= '0;
      n_m1_q         <= '0;
      src_q          <= '0;
      src_ok_q       <= 1'b0;
      detect_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        num_vertices_q <= cfg_wdata_i;
      end
      case (state_q)
        bfsp_pkg::ST_CLEAR: begin
          clr_q <= EA_W'(clr_q + 1'b1);
        end
        bfsp_pkg::ST_IDLE: begin
          clr_q    <= '0;
          k_q      <= '0;
          n_m1_q   <= VW'(n_eff - NV_W'(1));
          src_q    <= VW'(source_vertex_i);
          src_ok_q <= src_ok;
        end
        bfsp_pkg::ST_INIT: begin
          if (k_end) begin
            k_q      <= '0;
            j_q      <= '0;
            row_q    <= '0;
            pass_q   <= '0;
            detect_q <= src_ok_q && (n_m1_q == '0);
          end else begin
            k_q <= VW'(k_q + 1'b1);
          end
        end
        bfsp_pkg::ST_SCAN: begin
          if (k_end) begin
            k_q <= '0;
            if (j_end) begin
              j_q      <= '0;
              row_q    <= '0;
              pass_q   <= VW'(pass_q + 1'b1);
              detect_q <= detect_q || (VW'(pass_q + 1'b1) == n_m1_q);
            end else begin
              j_q   <= VW'(j_q + 1'b1);
              row_q <= EA_W'(row_q + EA_W'(MAX_VERTICES));
            end
          end else begin
            k_q <= VW'(k_q + 1'b1);
          end
        end
        bfsp_pkg::ST_DRAIN: begin
          k_q <= '0;
        end
        bfsp_pkg::ST_EMIT: begin
          k_q <= VW'(k_q + 1'b1);
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/bfsp_relax.sv]
module bfsp_relax #(
  parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS_DEF,
  localparam int VW = $clog2(MAX_VERTICES),
  localparam int DW = bfsp_pkg::DIST_W
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bfsp_pkg::issue_t                  iss_i,
  input  logic [VW-1:0]                     iss_addr_i,
  input  logic [WEIGHT_BITS:0]              edge_rdata_i,
  input  logic [DW:0]                       dist_rdata_i,
  output logic                              dist_we_o,
  output logic [VW-1:0]                     dist_waddr_o,
  output logic [DW:0]                       dist_wdata_o,
  output logic                              cycle_o,
  output logic                              result_valid_o,
  output logic [bfsp_pkg::VERT_W-1:0]       vertex_o,
  output logic signed [DW-1:0]              distance_o,
  output logic                              unreachable_o,
  output logic                              negative_cycle_o,
  output logic                              last_o
);

  localparam int SUM_W = ((DW > WEIGHT_BITS) ? DW : WEIGHT_BITS) + 1;
  localparam logic signed [SUM_W-1:0] SumHi = SUM_W'(2 ** (DW - 1) - 1);
  localparam logic signed [SUM_W-1:0] SumLo = SUM_W'(-(2 ** (DW - 1)));

  bfsp_pkg::issue_t s1_q;
  logic [VW-1:0]    a1_q;
  logic             wr_en_q;
  logic [VW-1:0]    wr_addr_q;
  logic [DW:0]      wr_data_q;
  logic [DW:0]      tail_q;
  logic             cycle_q;

  logic                       out_valid_q, out_unr_q, out_neg_q, out_last_q;
  logic [bfsp_pkg::VERT_W-1:0] out_vertex_q;
  logic signed [DW-1:0]       out_dist_q;

  logic [DW:0]                dist_cur;
  logic signed [DW-1:0]       tail_d, k_d, cand;
  logic signed [WEIGHT_BITS-1:0] w;
  logic signed [SUM_W-1:0]    sum, k_ext;
  logic                       tail_fin, k_fin, present, relax_hit, det_hit;

  // The read issued in the previous cycle misses a write made at the same edge.
  assign dist_cur = (wr_en_q && wr_addr_q == a1_q) ? wr_data_q : dist_rdata_i;

  assign tail_fin = tail_q[DW];
  assign tail_d   = $signed(tail_q[DW-1:0]);
  assign k_fin    = dist_cur[DW];
  assign k_d      = $signed(dist_cur[DW-1:0]);
  assign present  = edge_rdata_i[WEIGHT_BITS];
  assign w        = $signed(edge_rdata_i[WEIGHT_BITS-1:0]);

  assign sum   = SUM_W'(tail_d) + SUM_W'(w);
  assign k_ext = SUM_W'(k_d);

  always_comb begin
    if (sum > SumHi) begin
      cand = SumHi[DW-1:0];
    end else if (sum < SumLo) begin
      cand = SumLo[DW-1:0];
    end else begin
      cand = sum[DW-1:0];
    end
  end

  // Relaxation uses the clamped sum; detection compares the exact one.
  assign relax_hit = tail_fin && present && (!k_fin || cand < k_d);
  assign det_hit   = tail_fin && present && (!k_fin || sum < k_ext);

  always_comb begin
    dist_we_o    = 1'b0;
    dist_waddr_o = a1_q;
    dist_wdata_o = {1'b1, cand};
    case (s1_q.kind)
      bfsp_pkg::K_INIT: begin
        dist_we_o    = 1'b1;
        dist_wdata_o = {s1_q.seed, {DW{1'b0}}};
      end
      bfsp_pkg::K_EDGE: begin
        dist_we_o = !s1_q.detect && relax_hit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '{kind: bfsp_pkg::K_NONE, detect: 1'b0, self_loop: 1'b0,
                       seed: 1'b0, last: 1'b0};
      wr_en_q     <= 1'b0;
      cycle_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_q        <= iss_i;
      wr_en_q     <= dist_we_o;
      out_valid_q <= (s1_q.kind == bfsp_pkg::K_OUT) || (s1_q.kind == bfsp_pkg::K_NEG);
      if (s1_q.kind == bfsp_pkg::K_INIT) begin
        cycle_q <= 1'b0;
      end else if (s1_q.kind == bfsp_pkg::K_EDGE && s1_q.detect && det_hit) begin
        cycle_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q      <= iss_addr_i;
    wr_addr_q <= dist_waddr_o;
    wr_data_q <= dist_wdata_o;
    if (s1_q.kind == bfsp_pkg::K_TAIL) begin
      tail_q <= dist_cur;
    end else if (dist_we_o && s1_q.kind == bfsp_pkg::K_EDGE && s1_q.self_loop) begin
      // A self loop moves the tail itself; later heads in the row see the new value.
      tail_q <= dist_wdata_o;
    end
    if (s1_q.kind == bfsp_pkg::K_NEG) begin
      out_vertex_q <= '0;
      out_dist_q   <= '0;
      out_unr_q    <= 1'b0;
      out_neg_q    <= 1'b1;
      out_last_q   <= 1'b1;
    end else begin
      out_vertex_q <= bfsp_pkg::VERT_W'(a1_q);
      out_dist_q   <= k_fin ? k_d : '0;
      out_unr_q    <= !k_fin;
      out_neg_q    <= 1'b0;
      out_last_q   <= s1_q.last;
    end
  end

  assign cycle_o          = cycle_q;
  assign result_valid_o   = out_valid_q;
  assign vertex_o         = out_vertex_q;
  assign distance_o       = out_dist_q;
  assign unreachable_o    = out_unr_q;
  assign negative_cycle_o = out_neg_q;
  assign last_o           = out_last_q;

endmodule

[rtl/bellman_ford_shortest_paths_core.sv]
// Compute: busy time for n vertices in use is set by the relaxation loop, one edge per cycle
// over n passes whose rows each read the tail and then the n heads, plus the result words;
// the last result word appears on the outputs after busy falls.
// Edge write: taken while idle, busy stays low. Clear: busy over all MAX_VERTICES**2 slots.
// After reset the same clearing sweep runs before the first item is taken.
// Results come one per cycle on result_valid_o; the receiver cannot stall.
`include "bellman_ford_shortest_paths_core_assert.svh"

module bellman_ford_shortest_paths_core #(
  parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [1:0]                           operation_i,
  input  logic [bfsp_pkg::VERT_W-1:0]          from_vertex_i,
  input  logic [bfsp_pkg::VERT_W-1:0]          to_vertex_i,
  input  logic signed [WEIGHT_BITS-1:0]        weight_i,
  input  logic [bfsp_pkg::VERT_W-1:0]          source_vertex_i,
  input  logic                                 cfg_we_i,
  input  logic [bfsp_pkg::CFG_W-1:0]           cfg_wdata_i,
  output logic                                 result_valid_o,
  output logic [bfsp_pkg::VERT_W-1:0]          vertex_o,
  output logic signed [bfsp_pkg::DIST_W-1:0]   distance_o,
  output logic                                 unreachable_o,
  output logic                                 negative_cycle_o,
  output logic                                 last_o
);

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int EA_W = $clog2(MAX_VERTICES * MAX_VERTICES);
  localparam int DW   = bfsp_pkg::DIST_W;

  logic                 edge_we;
  logic [EA_W-1:0]      edge_waddr, edge_raddr;
  logic [WEIGHT_BITS:0] edge_wdata, edge_rdata;
  logic                 dist_we;
  logic [VW-1:0]        dist_waddr, iss_addr;
  logic [DW:0]          dist_wdata, dist_rdata;
  logic                 cycle;
  bfsp_pkg::issue_t     iss;

  bfsp_seq #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .operation_i     (operation_i),
    .from_vertex_i   (from_vertex_i),
    .to_vertex_i     (to_vertex_i),
    .weight_i        (weight_i),
    .source_vertex_i (source_vertex_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cycle_i         (cycle),
    .edge_we_o       (edge_we),
    .edge_waddr_o    (edge_waddr),
    .edge_wdata_o    (edge_wdata),
    .edge_raddr_o    (edge_raddr),
    .iss_o           (iss),
    .iss_addr_o      (iss_addr)
  );

  bfsp_ram #(
    .WIDTH (WEIGHT_BITS + 1),
    .DEPTH (MAX_VERTICES * MAX_VERTICES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  bfsp_ram #(
    .WIDTH (DW + 1),
    .DEPTH (MAX_VERTICES)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (iss_addr),
    .rdata_o (dist_rdata)
  );

  bfsp_relax #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_relax (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .iss_i            (iss),
    .iss_addr_i       (iss_addr),
    .edge_rdata_i     (edge_rdata),
    .dist_rdata_i     (dist_rdata),
    .dist_we_o        (dist_we),
    .dist_waddr_o     (dist_waddr),
    .dist_wdata_o     (dist_wdata),
    .cycle_o          (cycle),
    .result_valid_o   (result_valid_o),
    .vertex_o         (vertex_o),
    .distance_o       (distance_o),
    .unreachable_o    (unreachable_o),
    .negative_cycle_o (negative_cycle_o),
    .last_o           (last_o)
  );

  `BFSP_ASSERT_NEXT(a_compute_goes_busy,
                    start_i && !busy_o && operation_i == bfsp_pkg::OP_COMPUTE,
                    busy_o, "compute word taken without going busy")
  `BFSP_ASSERT_NOW(a_neg_is_final, result_valid_o && negative_cycle_o,
                   last_o && !unreachable_o && vertex_o == '0,
                   "negative cycle word malformed")
  `BFSP_ASSERT_NOW(a_unreachable_zero, result_valid_o && unreachable_o,
                   distance_o == '0 && !negative_cycle_o,
                   "unreachable word carries a distance")

endmodule
